// ----- design/depth_test_color_buffer_assert.svh -----
// Assertion macros for the depth test colour buffer RTL.
// Both expect clk and arst_n in scope.
`ifndef DEPTH_TEST_COLOR_BUFFER_ASSERT_SVH
`define DEPTH_TEST_COLOR_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define DTCB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: check failed");
`define DTCB_ASSERT_NEXT(lbl, cond, conseq) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("%m: check failed");
`else
`define DTCB_ASSERT(lbl, prop)
`define DTCB_ASSERT_NEXT(lbl, cond, conseq)
`endif
`endif

// ----- design/dtcb_pkg.sv -----
`default_nettype none
package dtcb_pkg;

	localparam int SCREEN_COLUMNS = 512;
	localparam int SCREEN_ROWS    = 512;
	localparam int PIXEL_COUNT    = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W         = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int PROD_W         = 22;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int OUTQ_DEPTH     = 2;

	localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(PIXEL_COUNT - 1);
	localparam logic [11:0]       COL_LIMIT   = 12'(SCREEN_COLUMNS);
	localparam logic [11:0]       ROW_LIMIT   = 12'(SCREEN_ROWS);
	localparam logic [23:0]       DEPTH_MIN   = 24'h800000;
	localparam logic [7:0]        CLEAR_ALPHA = 8'hFF;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_FRAG  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_FRAG,
		OP_READ,
		OP_READ_OFF
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [ADDR_W-1:0]  addr;
		logic signed [23:0] depth;
		logic [31:0]        rgba;
	} op_t;

	typedef struct packed {
		logic signed [23:0] depth;
		logic [31:0]        rgba;
	} pixel_t;

	typedef struct packed {
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
		logic signed [23:0] depth;
		logic               off_screen;
	} res_t;

	localparam pixel_t CLEAR_PIXEL = '{depth: DEPTH_MIN, rgba: {24'h000000, CLEAR_ALPHA}};

endpackage
`default_nettype wire

// ----- design/dtcb_front.sv -----
`default_nettype none
module dtcb_front import dtcb_pkg::*; (
	input  wire logic               push,
	input  wire logic               q_full,
	input  wire logic [1:0]         command,
	input  wire logic signed [11:0] pixel_x,
	input  wire logic signed [11:0] pixel_y,
	input  wire logic signed [23:0] depth,
	input  wire logic [7:0]         red,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         blue,
	input  wire logic [7:0]         alpha,
	output logic                    q_push,
	output op_t                     q_item
);

	logic              on_screen;
	logic              keep;
	logic [PROD_W-1:0] lin;

	assign on_screen = !pixel_x[11] && !pixel_y[11] &&
		({1'b0, pixel_x[10:0]} < COL_LIMIT) && ({1'b0, pixel_y[10:0]} < ROW_LIMIT);

	// row-major pixel index
	assign lin = PROD_W'(pixel_y[10:0]) * PROD_W'(SCREEN_COLUMNS) + PROD_W'(pixel_x[10:0]);

	always_comb begin
		q_item.addr  = lin[ADDR_W-1:0];
		q_item.depth = depth;
		q_item.rgba  = {red, green, blue, alpha};
		q_item.kind  = OP_CLEAR;
		keep         = 1'b0;
		unique case (command)
			CMD_CLEAR: begin
				q_item.kind = OP_CLEAR;
				keep        = 1'b1;
			end
			CMD_FRAG: begin
				// drop off-screen fragments here
				q_item.kind = OP_FRAG;
				keep        = on_screen;
			end
			CMD_READ: begin
				q_item.kind = on_screen ? OP_READ : OP_READ_OFF;
				keep        = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign q_push = push && !q_full && keep;

endmodule
`default_nettype wire

// ----- design/dtcb_queue.sv -----
`default_nettype none
module dtcb_queue import dtcb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  item_in,
	output logic      full,
	input  wire logic pop,
	output op_t       item_out,
	output logic      empty
);

	op_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign item_out = slot_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= item_in;
	end

endmodule
`default_nettype wire

// ----- design/dtcb_back.sv -----
`default_nettype none
`include "depth_test_color_buffer_assert.svh"
module dtcb_back import dtcb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire op_t  q_item,
	output logic      q_pop,
	input  wire logic pop,
	output logic      empty,
	output res_t      res
);

	pixel_t            mem [PIXEL_COUNT];
	pixel_t            rd_q;
	logic              sweep_q;
	logic [ADDR_W-1:0] sweep_cnt_q;
	logic              valid_s1;
	op_t               op_s1;
	logic              fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	pixel_t            fwd_data_q;

	res_t              oq_q [OUTQ_DEPTH];
	logic              owr_q;
	logic              ord_q;
	logic [1:0]        ocnt_q;

	pixel_t            cur;
	logic              s1_is_read;
	logic              oq_full;
	logic              s1_go;
	logic              s1_free;
	logic              take;
	logic              start_clear;
	logic              load;
	logic              frag_wr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	pixel_t            wdata;
	logic              oq_push;
	logic              oq_pop;
	res_t              oq_in;

	// the read issued with the last write sees old data: forward it
	assign cur = (fwd_valid_q && fwd_addr_q == op_s1.addr) ? fwd_data_q : rd_q;

	assign s1_is_read  = valid_s1 && (op_s1.kind == OP_READ || op_s1.kind == OP_READ_OFF);
	assign oq_full     = (ocnt_q == 2'(OUTQ_DEPTH));
	assign s1_go       = valid_s1 && !(s1_is_read && oq_full);
	assign s1_free     = !valid_s1 || s1_go;
	assign take        = s1_free && !sweep_q && !q_empty;
	assign q_pop       = take;
	assign start_clear = take && q_item.kind == OP_CLEAR;
	assign load        = take && !start_clear;
	assign frag_wr     = s1_go && op_s1.kind == OP_FRAG &&
		($signed(op_s1.depth) > $signed(cur.depth));

	always_comb begin
		priority if (sweep_q) begin
			we    = 1'b1;
			waddr = sweep_cnt_q;
			wdata = CLEAR_PIXEL;
		end else begin
			we    = frag_wr;
			waddr = op_s1.addr;
			wdata = '{depth: op_s1.depth, rgba: op_s1.rgba};
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (load) rd_q <= mem[q_item.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (sweep_q) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
				if (sweep_cnt_q == LAST_ADDR) sweep_q <= 1'b0;
			end else if (start_clear) begin
				sweep_q     <= 1'b1;
				sweep_cnt_q <= '0;
			end
			if (s1_free) valid_s1 <= load;
			if (we) fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) op_s1 <= q_item;
		if (we) begin
			fwd_addr_q <= waddr;
			fwd_data_q <= wdata;
		end
	end

	// result queue parts the memory pipe from the consumer
	assign oq_push = s1_go && s1_is_read;
	assign oq_pop  = pop && !empty;
	assign empty   = (ocnt_q == '0);
	assign res     = oq_q[ord_q];

	always_comb begin
		if (op_s1.kind == OP_READ) begin
			oq_in = '{red: cur.rgba[31:24], green: cur.rgba[23:16], blue: cur.rgba[15:8],
				alpha: cur.rgba[7:0], depth: cur.depth, off_screen: 1'b0};
		end else begin
			oq_in = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00,
				depth: 24'sh000000, off_screen: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (oq_push) owr_q <= !owr_q;
			if (oq_pop) ord_q <= !ord_q;
			ocnt_q <= ocnt_q + 2'(oq_push) - 2'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) oq_q[owr_q] <= oq_in;
	end

	`DTCB_ASSERT(a_no_take_in_sweep, !(sweep_q && q_pop))
	`DTCB_ASSERT(a_sweep_s1_exclusive, !(sweep_q && valid_s1))
	`DTCB_ASSERT(a_oq_no_overflow, !(oq_push && oq_full))
	`DTCB_ASSERT_NEXT(a_clear_starts_sweep, start_clear, sweep_q && sweep_cnt_q == '0)

endmodule
`default_nettype wire

// ----- design/depth_test_color_buffer.sv -----
// Depth-tested frame store, greater depth is nearer.
// Input channel: push/full. command 0 clears the frame, 1 writes a fragment
// (pixel_x, pixel_y, depth, red..alpha) if on screen and strictly nearer than
// the stored depth, 2 reads one pixel. Command 3 and off-screen fragments are
// dropped at the input.
// Result channel: empty/pop, one word per read; an off-screen read returns
// off_screen=1 with all data zero.
// Read path: a read passes the command queue write, the memory read and the
// result queue write before it shows on the result ports.
// Throughput: one command per cycle, unless a clear runs or a read waits on
// a full result queue; the frame memory, with one read port and one write
// port, does the read-modify-write of a fragment in one pipeline slot, with
// forwarding of the previous write.
// Clear: one pass over the memory, one pixel per cycle; commands keep being
// accepted until the 4-entry command queue fills. Reset starts the same
// pass, so the block raises full once the queue fills before the pass ends.
// Stall: when the consumer holds pop low, reads back up into the 2-entry
// result queue, then the pipe, then the command queue, then full.
`default_nettype none
module depth_test_color_buffer import dtcb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         command,
	input  wire logic signed [11:0] pixel_x,
	input  wire logic signed [11:0] pixel_y,
	input  wire logic signed [23:0] depth,
	input  wire logic [7:0]         red,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         blue,
	input  wire logic [7:0]         alpha,
	output logic                    empty,
	input  wire logic               pop,
	output logic [7:0]              out_red,
	output logic [7:0]              out_green,
	output logic [7:0]              out_blue,
	output logic [7:0]              out_alpha,
	output logic signed [23:0]      out_depth,
	output logic                    off_screen
);

	logic q_push;
	op_t  q_in;
	logic q_full;
	logic q_pop;
	op_t  q_head;
	logic q_empty;
	res_t res;

	dtcb_front u_front (
		.push    (push),
		.q_full  (q_full),
		.command (command),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.depth   (depth),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.alpha   (alpha),
		.q_push  (q_push),
		.q_item  (q_in)
	);

	dtcb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.item_out (q_head),
		.empty    (q_empty)
	);

	dtcb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_head),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign full       = q_full;
	assign out_red    = res.red;
	assign out_green  = res.green;
	assign out_blue   = res.blue;
	assign out_alpha  = res.alpha;
	assign out_depth  = res.depth;
	assign off_screen = res.off_screen;

endmodule
`default_nettype wire
